/* design/proportional_glyph_text_renderer_top_defines.svh */
// Assertion macros for the proportional glyph text renderer.
`ifndef PROPORTIONAL_GLYPH_TEXT_RENDERER_TOP_DEFINES_SVH
`define PROPORTIONAL_GLYPH_TEXT_RENDERER_TOP_DEFINES_SVH

// same-cycle implication
`define PGTR_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define PGTR_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* design/pgtr_pkg.sv */
// Shared types and constants of the proportional glyph text renderer.
package pgtr_pkg;

    localparam int GLYPH_SIZE     = 12;
    localparam int COORD_BITS     = 12;
    localparam int NUM_GLYPHS_DEF = 256;
    localparam int CODE_BITS      = 8;
    localparam int COLIDX_BITS    = 4;
    localparam int MASK_BITS      = GLYPH_SIZE;
    localparam int SW_BITS        = 12;
    localparam int SP_BITS        = 4;
    localparam int CFG_DATA_BITS  = 12;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CW             = $clog2(GLYPH_SIZE);
    localparam int LW             = $clog2(GLYPH_SIZE + 1);

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_SET_POS = 2'd1;
    localparam logic [1:0] OP_DRAW    = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHAR_SPACING = 1'd1;

    localparam logic [CODE_BITS-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CODE_BITS-1:0] CODE_SPACE   = 8'd32;

    localparam int SPACE_ADVANCE    = 4;
    localparam int ABSENT_ADVANCE   = GLYPH_SIZE + 1;
    localparam int SCREEN_WIDTH_RST = 640;

    typedef struct packed {
        logic [1:0]             operation;
        logic [CODE_BITS-1:0]   char_code;
        logic [COLIDX_BITS-1:0] column_index;
        logic [MASK_BITS-1:0]   column_mask;
        logic [COORD_BITS-1:0]  start_x;
        logic [COORD_BITS-1:0]  start_y;
    } cmd_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [MASK_BITS-1:0]  row_mask;
        logic                  last_column;
    } pix_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_BOUNDS,
        ST_EMIT
    } state_t;

endpackage

/* design/pgtr_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module pgtr_ram #(
    parameter int DEPTH = pgtr_pkg::NUM_GLYPHS_DEF * pgtr_pkg::GLYPH_SIZE,
    parameter int WIDTH = pgtr_pkg::GLYPH_SIZE
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/pgtr_out_buf.sv */
// Two-entry output buffer (output register plus skid) for column items.
module pgtr_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pgtr_pkg::pix_t   push_data,
    output logic             valid,
    input  logic             stall,
    output pgtr_pkg::pix_t   data,
    output logic             room
);

    logic           out_vld_reg, out_vld_next;
    logic           skid_vld_reg, skid_vld_next;
    pgtr_pkg::pix_t out_data_reg, out_data_next;
    pgtr_pkg::pix_t skid_data_reg, skid_data_next;
    logic           pop;
    logic [1:0]     occ;

    assign pop   = out_vld_reg && !stall;
    assign valid = out_vld_reg;
    assign data  = out_data_reg;

    // slots held in the next cycle; a read issued now lands then
    assign occ  = 2'(out_vld_reg) + 2'(skid_vld_reg) + 2'(push) - 2'(pop);
    assign room = (occ < 2'd2);

    always_comb
    begin
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        if (!out_vld_reg || pop)
        begin
            if (skid_vld_reg)
            begin
                out_vld_next   = 1'b1;
                out_data_next  = skid_data_reg;
                skid_vld_next  = push;
                skid_data_next = push_data;
            end
            else
            begin
                out_vld_next  = push;
                out_data_next = push_data;
            end
        end
        else if (push)
        begin
            skid_vld_next  = 1'b1;
            skid_data_next = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

/* design/proportional_glyph_text_renderer_top.sv */
// Top level of the proportional glyph text renderer: control, cursor and glyph stores.
//
// Glyph columns live in a one-read, one-write column RAM and each glyph's left/right ink
// bounds in a small bounds RAM; present bits are flip-flops cleared by reset. The final
// column of a glyph's load starts a bounds scan that reads the glyph's twelve columns
// back through the column RAM read port, one per cycle, before the next item is taken.
// Set-position, newline, space and absent-glyph items are handled without leaving idle.
// A drawn glyph spanning n columns from its leftmost to its rightmost inked column needs
// one bounds RAM read, then one column RAM read per emitted column item, slowed only when
// the two-entry output buffer is full because the pix side stalls.
`include "proportional_glyph_text_renderer_top_defines.svh"

module proportional_glyph_text_renderer_top #(
    parameter int NUM_GLYPHS = pgtr_pkg::NUM_GLYPHS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_stall,
    input  pgtr_pkg::cmd_t                        cmd,
    output logic                                  pix_valid,
    input  logic                                  pix_stall,
    output pgtr_pkg::pix_t                        pix,
    input  logic                                  cfg_we,
    input  logic [pgtr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pgtr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int G   = pgtr_pkg::GLYPH_SIZE;
    localparam int CB  = pgtr_pkg::COORD_BITS;
    localparam int CW  = pgtr_pkg::CW;
    localparam int LW  = pgtr_pkg::LW;
    localparam int GW  = $clog2(NUM_GLYPHS);
    localparam int AW  = $clog2(NUM_GLYPHS * G);
    localparam int BW  = LW + CW;
    localparam int MB  = pgtr_pkg::MASK_BITS;

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CB] ? {CB{1'b1}} : s[CB-1:0];
    endfunction

    function automatic logic [CB-1:0] advance(input logic [LW-1:0] l, input logic [CW-1:0] r,
                                              input logic [pgtr_pkg::SP_BITS-1:0] sp);
        return CB'(r) + CB'(2) - CB'(l) + CB'(sp);
    endfunction

    pgtr_pkg::state_t state_reg, state_next;

    logic [pgtr_pkg::SW_BITS-1:0] screen_width_reg, screen_width_next;
    logic [pgtr_pkg::SP_BITS-1:0] char_spacing_reg, char_spacing_next;
    logic [CB-1:0] cursor_x_reg, cursor_x_next;
    logic [CB-1:0] cursor_y_reg, cursor_y_next;
    logic [CB-1:0] base_x_reg, base_x_next;
    logic [GW-1:0] glyph_reg, glyph_next;
    logic [CW-1:0] col_reg, col_next;
    logic [LW-1:0] left_reg, left_next;
    logic [CW-1:0] right_reg, right_next;
    logic          found_reg, found_next;
    logic          scan_vld_reg, scan_vld_next;
    logic [CW-1:0] scan_col_d_reg, scan_col_d_next;
    logic          emit_vld_reg, emit_vld_next;
    logic [CB-1:0] emit_x_reg, emit_x_next;
    logic          emit_last_reg, emit_last_next;

    logic present_reg [NUM_GLYPHS];

    logic          cmd_accept;
    logic          code_ok;
    logic          load_ok;
    logic          scan_kick;
    logic          in_scan;
    logic          draw_glyph;
    logic [GW-1:0] code_idx;

    logic          col_we, col_re;
    logic [AW-1:0] col_waddr, col_raddr;
    logic [MB-1:0] col_rdata;
    logic          bnd_we, bnd_re;
    logic [BW-1:0] bnd_wdata, bnd_rdata;
    logic [LW-1:0] bnd_l;
    logic [CW-1:0] bnd_r;
    logic          bnd_blank;
    logic          present_clr, present_set;

    logic          scan_found_upd;
    logic [LW-1:0] scan_left_upd;
    logic [CW-1:0] scan_right_upd;

    logic          room;
    logic          emit_issue;
    logic          emit_last;
    logic          wrap;
    logic [CB-1:0] x0;
    pgtr_pkg::pix_t push_data;

    assign code_idx   = cmd.char_code[GW-1:0];
    assign cmd_accept = cmd_valid && (state_reg == pgtr_pkg::ST_IDLE);
    assign code_ok    = ({1'b0, cmd.char_code} < (pgtr_pkg::CODE_BITS + 1)'(NUM_GLYPHS));
    assign load_ok    = (cmd.operation == pgtr_pkg::OP_LOAD) && code_ok
                        && (cmd.column_index < pgtr_pkg::COLIDX_BITS'(G));
    assign scan_kick  = cmd_accept && load_ok
                        && (cmd.column_index == pgtr_pkg::COLIDX_BITS'(G - 1));
    assign in_scan    = (state_reg == pgtr_pkg::ST_SCAN) || (state_reg == pgtr_pkg::ST_SCAN_END);
    assign draw_glyph = (cmd.operation == pgtr_pkg::OP_DRAW)
                        && (cmd.char_code != pgtr_pkg::CODE_NEWLINE)
                        && (cmd.char_code != pgtr_pkg::CODE_SPACE)
                        && code_ok && present_reg[code_idx];

    assign bnd_l     = bnd_rdata[BW-1:CW];
    assign bnd_r     = bnd_rdata[CW-1:0];
    assign bnd_blank = (bnd_l > LW'(bnd_r));

    assign wrap = ({1'b0, cursor_x_reg} + (CB + 1)'(G)) > (CB + 1)'(screen_width_reg);
    assign x0   = wrap ? base_x_reg : cursor_x_reg;

    assign emit_last = (col_reg == right_reg);

    // running ink bounds over the column data returning from the scan reads
    always_comb
    begin
        scan_found_upd = found_reg;
        scan_left_upd  = left_reg;
        scan_right_upd = right_reg;
        if (scan_vld_reg && (col_rdata != '0))
        begin
            if (!found_reg)
            begin
                scan_left_upd = LW'(scan_col_d_reg);
            end
            scan_found_upd = 1'b1;
            scan_right_upd = scan_col_d_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pgtr_pkg::ST_IDLE:
            begin
                if (scan_kick)
                begin
                    state_next = pgtr_pkg::ST_SCAN;
                end
                else if (cmd_accept && draw_glyph)
                begin
                    state_next = pgtr_pkg::ST_BOUNDS;
                end
            end
            pgtr_pkg::ST_SCAN:
            begin
                if (col_reg == CW'(G - 1))
                begin
                    state_next = pgtr_pkg::ST_SCAN_END;
                end
            end
            pgtr_pkg::ST_SCAN_END:
            begin
                state_next = pgtr_pkg::ST_IDLE;
            end
            pgtr_pkg::ST_BOUNDS:
            begin
                state_next = bnd_blank ? pgtr_pkg::ST_IDLE : pgtr_pkg::ST_EMIT;
            end
            pgtr_pkg::ST_EMIT:
            begin
                if (room && emit_last)
                begin
                    state_next = pgtr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pgtr_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_stall   = (state_reg != pgtr_pkg::ST_IDLE);
        col_we      = cmd_accept && load_ok;
        col_waddr   = AW'(AW'(code_idx) * AW'(G)) + AW'(cmd.column_index);
        col_raddr   = AW'(AW'(glyph_reg) * AW'(G)) + AW'(col_reg);
        col_re      = 1'b0;
        bnd_re      = cmd_accept;
        bnd_we      = 1'b0;
        bnd_wdata   = scan_found_upd ? {scan_left_upd, scan_right_upd}
                                     : {LW'(G), CW'(G - 1)};
        present_clr = cmd_accept && load_ok && (cmd.column_index == '0);
        present_set = 1'b0;
        emit_issue  = 1'b0;
        case (state_reg)
            pgtr_pkg::ST_SCAN:
            begin
                col_re = 1'b1;
            end
            pgtr_pkg::ST_SCAN_END:
            begin
                bnd_we      = 1'b1;
                present_set = 1'b1;
            end
            pgtr_pkg::ST_EMIT:
            begin
                col_re     = room;
                emit_issue = room;
            end
            default:
            begin
                col_re = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        screen_width_next = screen_width_reg;
        char_spacing_next = char_spacing_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        base_x_next       = base_x_reg;
        glyph_next        = glyph_reg;
        col_next          = col_reg;
        left_next         = scan_left_upd;
        right_next        = scan_right_upd;
        found_next        = scan_found_upd;
        scan_vld_next     = 1'b0;
        scan_col_d_next   = col_reg;
        emit_vld_next     = 1'b0;
        emit_x_next       = sat_add(cursor_x_reg, CB'(LW'(col_reg) - left_reg));
        emit_last_next    = emit_last;

        if (cfg_we)
        begin
            case (cfg_index)
                pgtr_pkg::CFG_SCREEN_WIDTH: screen_width_next = cfg_data[pgtr_pkg::SW_BITS-1:0];
                pgtr_pkg::CFG_CHAR_SPACING: char_spacing_next = cfg_data[pgtr_pkg::SP_BITS-1:0];
                default:                    screen_width_next = screen_width_reg;
            endcase
        end

        case (state_reg)
            pgtr_pkg::ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.operation)
                        pgtr_pkg::OP_LOAD:
                        begin
                            glyph_next = code_idx;
                            col_next   = '0;
                            found_next = 1'b0;
                        end
                        pgtr_pkg::OP_SET_POS:
                        begin
                            base_x_next   = cmd.start_x;
                            cursor_x_next = cmd.start_x;
                            cursor_y_next = cmd.start_y;
                        end
                        pgtr_pkg::OP_DRAW:
                        begin
                            glyph_next = code_idx;
                            if (cmd.char_code == pgtr_pkg::CODE_NEWLINE)
                            begin
                                cursor_y_next = sat_add(cursor_y_reg, CB'(G));
                                cursor_x_next = base_x_reg;
                            end
                            else if (cmd.char_code == pgtr_pkg::CODE_SPACE)
                            begin
                                cursor_x_next = sat_add(cursor_x_reg,
                                                        CB'(pgtr_pkg::SPACE_ADVANCE));
                            end
                            else if (!draw_glyph)
                            begin
                                cursor_x_next = sat_add(cursor_x_reg,
                                                        CB'(pgtr_pkg::ABSENT_ADVANCE));
                            end
                        end
                        default:
                        begin
                            glyph_next = glyph_reg;
                        end
                    endcase
                end
            end
            pgtr_pkg::ST_SCAN:
            begin
                scan_vld_next = 1'b1;
                col_next      = col_reg + CW'(1);
            end
            pgtr_pkg::ST_BOUNDS:
            begin
                left_next  = bnd_l;
                right_next = bnd_r;
                col_next   = bnd_l[CW-1:0];
                if (wrap)
                begin
                    cursor_y_next = sat_add(cursor_y_reg, CB'(G));
                end
                cursor_x_next = bnd_blank ? sat_add(x0, advance(bnd_l, bnd_r, char_spacing_reg))
                                          : x0;
            end
            pgtr_pkg::ST_EMIT:
            begin
                left_next  = left_reg;
                right_next = right_reg;
                if (emit_issue)
                begin
                    emit_vld_next = 1'b1;
                    col_next      = col_reg + CW'(1);
                    if (emit_last)
                    begin
                        cursor_x_next = sat_add(cursor_x_reg,
                                                advance(left_reg, right_reg, char_spacing_reg));
                    end
                end
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pgtr_pkg::ST_IDLE;
            screen_width_reg <= pgtr_pkg::SW_BITS'(pgtr_pkg::SCREEN_WIDTH_RST);
            char_spacing_reg <= '0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            base_x_reg       <= '0;
            col_reg          <= '0;
            found_reg        <= 1'b0;
            scan_vld_reg     <= 1'b0;
            emit_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            screen_width_reg <= screen_width_next;
            char_spacing_reg <= char_spacing_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            base_x_reg       <= base_x_next;
            col_reg          <= col_next;
            found_reg        <= found_next;
            scan_vld_reg     <= scan_vld_next;
            emit_vld_reg     <= emit_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg      <= glyph_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        scan_col_d_reg <= scan_col_d_next;
        emit_x_reg     <= emit_x_next;
        emit_last_reg  <= emit_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GLYPHS; i++)
            begin
                present_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (present_clr)
            begin
                present_reg[code_idx] <= 1'b0;
            end
            if (present_set)
            begin
                present_reg[glyph_reg] <= 1'b1;
            end
        end
    end

    pgtr_ram #(
        .DEPTH (NUM_GLYPHS * G),
        .WIDTH (MB)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (cmd.column_mask),
        .re    (col_re),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    pgtr_ram #(
        .DEPTH (NUM_GLYPHS),
        .WIDTH (BW)
    ) u_bnd_ram (
        .clk   (clk),
        .we    (bnd_we),
        .waddr (glyph_reg),
        .wdata (bnd_wdata),
        .re    (bnd_re),
        .raddr (code_idx),
        .rdata (bnd_rdata)
    );

    assign push_data = '{pixel_x:     emit_x_reg,
                         pixel_y:     cursor_y_reg,
                         row_mask:    col_rdata,
                         last_column: emit_last_reg};

    pgtr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit_vld_reg),
        .push_data (push_data),
        .valid     (pix_valid),
        .stall     (pix_stall),
        .data      (pix),
        .room      (room)
    );

    `PGTR_ASSERT_NEXT(a_scan_start, scan_kick, state_reg == pgtr_pkg::ST_SCAN, "scan not started")
    `PGTR_ASSERT_NEXT(a_push_after_emit, emit_issue, emit_vld_reg, "column read not pushed")
    `PGTR_ASSERT_NEXT(a_scan_x_hold, in_scan, $stable(cursor_x_reg), "cursor x moved in scan")
    `PGTR_ASSERT_NEXT(a_scan_y_hold, in_scan, $stable(cursor_y_reg), "cursor y moved in scan")

endmodule
